[design/slse_pkg.sv]
`timescale 1ns / 1ps
package slse_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] stored_count;
  } rsp_t;

  typedef struct packed {
    logic               active;
    logic [1:0]         op;
    logic               full;
    logic               hit;
    logic               placed;
    logic signed [31:0] value;
  } tok_t;

endpackage

[design/sorted_linked_set_engine_core.sv]
`timescale 1ns / 1ps
// Sorted set of distinct signed 32-bit values held in a chain of NODE_SLOTS-1
// cells, ascending from cell 0 with occupied cells packed at the front. Each
// request (insert, search, delete) enters cell 0 and moves one cell per cycle
// to the end of the chain; inserts shift larger values back one cell and
// deletes pull the tail forward one cell, both as the request passes. One
// request is in flight at a time: its response is registered as the request
// leaves the last cell, and the next request may be taken as soon as that
// response is presented, even while it still waits. The chain stops while a
// request has reached its end and the previous response cannot be handed on.
// At most NODE_SLOTS-1 values are held; stored_count is the count modulo 128.
module sorted_linked_set_engine_core #(
  parameter int NODE_SLOTS = 128
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  slse_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output slse_pkg::rsp_t rsp
);
  import slse_pkg::*;

  localparam int CAP = NODE_SLOTS - 1;
  localparam int CW  = $clog2(NODE_SLOTS);

  tok_t               tok [CAP+1];
  logic [CAP-1:0]     cell_valid;
  logic signed [31:0] cell_value [CAP];
  logic [CAP-1:0]     tok_act;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic               busy;
  logic               en;
  logic               done;
  logic [1:0]         status;
  tok_t               last;

  assign req_ready = !busy;
  assign last      = tok[CAP];
  assign en        = !(last.active && rsp_valid && !rsp_ready);
  assign done      = last.active && en;

  always_comb begin
    tok[0]        = '0;
    tok[0].active = req_valid && req_ready;
    tok[0].op     = req.req_type;
    tok[0].value  = req.value;
    tok[0].full   = (count == CW'(CAP));
  end

  genvar i;
  generate
    for (i = 0; i < CAP; i++) begin : gen_cell
      logic               nv;
      logic signed [31:0] nval;
      if (i == CAP - 1) begin : gen_tail
        assign nv   = 1'b0;
        assign nval = '0;
      end else begin : gen_mid
        assign nv   = cell_valid[i+1];
        assign nval = cell_value[i+1];
      end
      slse_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .en        (en),
        .tok_in    (tok[i]),
        .nbr_valid (nv),
        .nbr_value (nval),
        .tok_out   (tok[i+1]),
        .valid     (cell_valid[i]),
        .value     (cell_value[i])
      );
      assign tok_act[i] = tok[i+1].active;
    end
  endgenerate

  always_comb begin
    status     = ST_MISSING;
    count_next = count;
    case (last.op)
      OP_INSERT: begin
        if (last.hit) begin
          status = ST_DUP;
        end else if (last.full) begin
          status = ST_FULL;
        end else begin
          status     = ST_OK;
          count_next = count + CW'(1);
        end
      end
      OP_SEARCH: begin
        if (last.hit) status = ST_OK;
      end
      OP_DELETE: begin
        if (last.hit) begin
          status     = ST_OK;
          count_next = count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (req_valid && req_ready) begin
        busy <= 1'b1;
      end
      if (done) begin
        busy      <= 1'b0;
        rsp_valid <= 1'b1;
        count     <= count_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp.status       <= status;
      rsp.stored_count <= 7'(count_next);
    end
  end

  a_packed: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("occupied cells not packed at chain front");

  a_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ($countones(cell_valid) == int'(count)))
    else $error("value count disagrees with occupied cells");

  a_one_tok: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_act) && (busy || (tok_act == '0)))
    else $error("request tokens in chain inconsistent with busy");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (done && last.op == OP_INSERT && !last.hit && !last.full)
    |=> (count == $past(count) + CW'(1)))
    else $error("successful insert did not advance count");

endmodule

[design/slse_cell.sv]
`timescale 1ns / 1ps
module slse_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  slse_pkg::tok_t      tok_in,
  input  logic                nbr_valid,
  input  logic signed [31:0]  nbr_value,
  output slse_pkg::tok_t      tok_out,
  output logic                valid,
  output logic signed [31:0]  value
);
  import slse_pkg::*;

  tok_t               tok_next;
  logic               valid_next;
  logic signed [31:0] value_next;
  logic               match;

  assign match = valid && (value == tok_in.value);

  always_comb begin
    tok_next   = tok_in;
    valid_next = valid;
    value_next = value;
    if (tok_in.active) begin
      case (tok_in.op)
        OP_INSERT: begin
          if (tok_in.full) begin
            if (match) tok_next.hit = 1'b1;
          end else if (!tok_in.hit && !tok_in.placed) begin
            if (match) begin
              tok_next.hit = 1'b1;
            end else if (!valid) begin
              valid_next      = 1'b1;
              value_next      = tok_in.value;
              tok_next.placed = 1'b1;
            end else if (value > tok_in.value) begin
              // swap: keep the smaller value, carry the displaced one on
              value_next     = tok_in.value;
              tok_next.value = value;
            end
          end
        end
        OP_SEARCH: begin
          if (match) tok_next.hit = 1'b1;
        end
        OP_DELETE: begin
          if (tok_in.hit || match) begin
            valid_next   = nbr_valid;
            value_next   = nbr_value;
            tok_next.hit = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      tok_out <= '0;
    end else if (en) begin
      valid   <= valid_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= value_next;
    end
  end

endmodule
